// File: src/wbss_pkg.sv
`timescale 1ns / 1ps
// wbss_pkg: shared types and constants for the wildcard byte signature scan.
// No dependencies.
package wbss_pkg;

    localparam int POS_W      = 5;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int RES_W      = 32;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_TOK_LO   = 3'd0,
        REG_TOK_HI   = 3'd1,
        REG_WILD     = 3'd2,
        REG_MEMBER   = 3'd3,
        REG_GSTART   = 3'd4,
        REG_TCOUNT   = 3'd5,
        REG_CURSOR   = 3'd6,
        REG_FIND_ALL = 3'd7
    } reg_idx_t;

    // Kind of entry moving down the cell chain
    typedef struct packed {
        logic valid;
        logic flush;
        logic close;
    } ctl_t;

    // Walk state of one start position
    typedef struct packed {
        logic             alive;
        logic             cset;
        logic             skip;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] gpos;
        logic [POS_W-1:0] cursor;
    } jstate_t;

    // Per-token configuration seen by one cell
    typedef struct packed {
        logic [7:0] tok;
        logic       wild;
        logic       member;
        logic       gstart;
        logic       opens;
        logic       active;
        logic       cur_hit;
    } tcfg_t;

endpackage

// File: src/wbss_if.sv
`timescale 1ns / 1ps
// wbss_in_if / wbss_out_if: valid/ready channels of the signature scan.
// No dependencies.
interface wbss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbss_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] match_offset;
    logic        found;
    logic        end_of_scan;
    modport source (output valid, output match_offset, output found, output end_of_scan,
                    input ready);
    modport sink   (input valid, input match_offset, input found, input end_of_scan,
                    output ready);
endinterface

// File: src/wbss_cell.sv
`timescale 1ns / 1ps
// wbss_cell: one token stage of the match chain; applies one token to a start.
// Depends on wbss_pkg.
module wbss_cell #(
    parameter int SPAN = 16,
    parameter int OB   = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  wbss_pkg::tcfg_t             cfg,
    input  wbss_pkg::ctl_t              in_ctl,
    input  wbss_pkg::jstate_t           in_js,
    input  logic [wbss_pkg::POS_W-1:0]  in_b,
    input  logic [SPAN-1:0][7:0]        in_win,
    input  logic [OB-1:0]               in_start,
    output wbss_pkg::ctl_t              out_ctl,
    output wbss_pkg::jstate_t           out_js,
    output logic [wbss_pkg::POS_W-1:0]  out_b,
    output logic [SPAN-1:0][7:0]        out_win,
    output logic [OB-1:0]               out_start
);
    import wbss_pkg::*;

    localparam int IW = $clog2(SPAN);

    ctl_t               ctl_reg;
    jstate_t            js_reg;
    jstate_t            js_next;
    logic [POS_W-1:0]   b_reg;
    logic [SPAN-1:0][7:0] win_reg;
    logic [OB-1:0]      start_reg;
    logic [POS_W:0]     idx;
    logic [POS_W-1:0]   gp;
    logic               ok;

    always_comb
    begin
        js_next = in_js;
        idx     = {1'b0, in_b} + {1'b0, in_js.pos};
        gp      = in_js.gpos;
        ok      = 1'b0;
        if (in_ctl.valid && !in_ctl.close && in_js.alive && cfg.active)
        begin
            if (!(in_js.skip && cfg.member && !cfg.gstart))
            begin
                js_next.skip = 1'b0;
                if (!in_js.cset && cfg.cur_hit)
                begin
                    js_next.cursor = in_js.pos;
                    js_next.cset   = 1'b1;
                end
                if (idx >= (POS_W+1)'(SPAN))
                begin
                    js_next.alive = 1'b0;
                end
                else
                begin
                    if (cfg.member && cfg.opens)
                    begin
                        gp = in_js.pos;
                    end
                    js_next.gpos = gp;
                    ok = cfg.wild || (in_win[idx[IW-1:0]] == cfg.tok);
                    if (ok)
                    begin
                        js_next.pos = in_js.pos + 1'b1;
                    end
                    else if (!cfg.member)
                    begin
                        js_next.alive = 1'b0;
                    end
                    else
                    begin
                        js_next.skip = 1'b1;
                        js_next.pos  = gp;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            js_reg    <= js_next;
            b_reg     <= in_b;
            win_reg   <= in_win;
            start_reg <= in_start;
        end
    end

    assign out_ctl   = ctl_reg;
    assign out_js    = js_reg;
    assign out_b     = b_reg;
    assign out_win   = win_reg;
    assign out_start = start_reg;

endmodule

// File: src/wildcard_byte_signature_scan.sv
`timescale 1ns / 1ps
// Each start walks the token cell chain, then its result is registered (SPAN = min(MAX_TOKENS,16)).
// One byte per cycle outside a flush; the token chain advances once per cycle unless out stalls.
// A last byte blocks input while the pending starts and an end entry are fed.
// Reset (rst_n, async, active low) clears chain valids, window state and config to defaults.
// Depends on wbss_pkg, wbss_if and wbss_cell.
module wildcard_byte_signature_scan #(
    parameter int MAX_TOKENS  = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [wbss_pkg::REG_IDX_W-1:0]   cfg_idx,
    input  logic [wbss_pkg::CFG_DATA_W-1:0]  cfg_data,
    wbss_in_if.sink                          in_ch,
    wbss_out_if.source                       out_ch
);
    import wbss_pkg::*;

    localparam int SPAN = (MAX_TOKENS < 16) ? MAX_TOKENS : 16;
    localparam int OB   = OFFSET_BITS;

    logic [63:0]      tok_lo_reg;
    logic [63:0]      tok_hi_reg;
    logic [15:0]      wild_reg;
    logic [15:0]      memb_reg;
    logic [15:0]      gst_reg;
    logic [POS_W-1:0] tcount_reg;
    logic [POS_W-1:0] cidx_reg;
    logic             fall_reg;

    logic [127:0]     tok_all;
    logic [15:0]      prev_memb;
    logic [POS_W-1:0] n_used;
    tcfg_t            tcfg [SPAN];

    ctl_t                 st_ctl   [SPAN+1];
    jstate_t              st_js    [SPAN+1];
    logic [POS_W-1:0]     st_b     [SPAN+1];
    logic [SPAN-1:0][7:0] st_win   [SPAN+1];
    logic [OB-1:0]        st_start [SPAN+1];

    logic [SPAN-1:0][7:0] win_reg;
    logic [SPAN-1:0][7:0] win_new;
    logic [OB-1:0]        seen_reg;
    logic [OB-1:0]        seen_new;
    logic [POS_W-1:0]     fill_reg;
    logic [POS_W-1:0]     fill_new;
    logic                 flush_reg;
    logic [POS_W-1:0]     flb_reg;
    logic                 adv;
    logic                 accept;

    logic                 out_valid_reg;
    logic [RES_W-1:0]     out_ofs_reg;
    logic                 out_found_reg;
    logic                 out_eos_reg;
    logic                 pend_v_reg;
    logic [RES_W-1:0]     pend_ofs_reg;
    logic                 first_reg;

    ctl_t                 t_ctl;
    jstate_t              t_js;
    logic [POS_W-1:0]     cur_f;
    logic [OB-1:0]        ofs_full;
    logic [OB+RES_W-1:0]  ofs_ext;
    logic                 hit;
    logic                 push;
    logic [RES_W-1:0]     push_ofs;
    logic                 push_found;
    logic                 push_eos;

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_lo_reg <= '0;
            tok_hi_reg <= '0;
            wild_reg   <= '0;
            memb_reg   <= '0;
            gst_reg    <= '0;
            tcount_reg <= POS_W'(1);
            cidx_reg   <= '0;
            fall_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_idx))
                REG_TOK_LO:   tok_lo_reg <= cfg_data;
                REG_TOK_HI:   tok_hi_reg <= cfg_data;
                REG_WILD:     wild_reg   <= cfg_data[15:0];
                REG_MEMBER:   memb_reg   <= cfg_data[15:0];
                REG_GSTART:   gst_reg    <= cfg_data[15:0];
                REG_TCOUNT:   tcount_reg <= cfg_data[POS_W-1:0];
                REG_CURSOR:   cidx_reg   <= cfg_data[POS_W-1:0];
                REG_FIND_ALL: fall_reg   <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    assign tok_all   = {tok_hi_reg, tok_lo_reg};
    assign prev_memb = {memb_reg[14:0], 1'b0};
    assign n_used    = (tcount_reg < POS_W'(SPAN)) ? tcount_reg : POS_W'(SPAN);

    always_comb
    begin
        for (int j = 0; j < SPAN; j++)
        begin
            tcfg[j].tok     = tok_all[8*j +: 8];
            tcfg[j].wild    = wild_reg[j];
            tcfg[j].member  = memb_reg[j];
            tcfg[j].gstart  = gst_reg[j];
            tcfg[j].opens   = gst_reg[j] || !prev_memb[j];
            tcfg[j].active  = POS_W'(j) < n_used;
            tcfg[j].cur_hit = POS_W'(j) >= cidx_reg;
        end
    end

    // Input side and start feeder
    assign adv          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready  = adv && !flush_reg;
    assign accept       = in_ch.valid && in_ch.ready;
    assign win_new      = {in_ch.data_byte, win_reg[SPAN-1:1]};
    assign seen_new     = seen_reg + OB'(1);
    assign fill_new     = (fill_reg == POS_W'(SPAN)) ? fill_reg : fill_reg + POS_W'(1);

    always_comb
    begin
        st_ctl[0]   = '0;
        st_js[0]    = '0;
        st_js[0].alive = 1'b1;
        st_b[0]     = flb_reg;
        st_win[0]   = win_reg;
        st_start[0] = seen_reg - OB'(SPAN) + OB'(flb_reg);
        if (accept && !in_ch.last_byte)
        begin
            st_ctl[0].valid = (fill_new == POS_W'(SPAN));
            st_b[0]         = '0;
            st_win[0]       = win_new;
            st_start[0]     = seen_new - OB'(SPAN);
        end
        else if (flush_reg)
        begin
            st_ctl[0].valid = 1'b1;
            if (flb_reg < POS_W'(SPAN))
            begin
                st_ctl[0].flush = 1'b1;
            end
            else
            begin
                st_ctl[0].close = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= '0;
            fill_reg  <= '0;
            flush_reg <= 1'b0;
            flb_reg   <= '0;
        end
        else if (accept)
        begin
            seen_reg <= seen_new;
            fill_reg <= fill_new;
            if (in_ch.last_byte)
            begin
                flush_reg <= 1'b1;
                flb_reg   <= POS_W'(SPAN) - fill_new;
            end
        end
        else if (flush_reg && adv)
        begin
            if (flb_reg < POS_W'(SPAN))
            begin
                flb_reg <= flb_reg + POS_W'(1);
            end
            else
            begin
                flush_reg <= 1'b0;
                seen_reg  <= '0;
                fill_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg <= win_new;
        end
    end

    // Token chain
    for (genvar g = 0; g < SPAN; g++)
    begin : g_cell
        wbss_cell #(
            .SPAN (SPAN),
            .OB   (OB)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .cfg       (tcfg[g]),
            .in_ctl    (st_ctl[g]),
            .in_js     (st_js[g]),
            .in_b      (st_b[g]),
            .in_win    (st_win[g]),
            .in_start  (st_start[g]),
            .out_ctl   (st_ctl[g+1]),
            .out_js    (st_js[g+1]),
            .out_b     (st_b[g+1]),
            .out_win   (st_win[g+1]),
            .out_start (st_start[g+1])
        );
    end

    // Result side
    assign t_ctl    = st_ctl[SPAN];
    assign t_js     = st_js[SPAN];
    assign cur_f    = t_js.cset ? t_js.cursor : t_js.pos;
    assign ofs_full = st_start[SPAN] + OB'(cur_f);
    assign ofs_ext  = {{RES_W{1'b0}}, ofs_full};
    assign hit      = t_ctl.valid && !t_ctl.close && t_js.alive && (fall_reg || !first_reg);

    always_comb
    begin
        push       = 1'b0;
        push_ofs   = ofs_ext[RES_W-1:0];
        push_found = 1'b1;
        push_eos   = 1'b0;
        if (t_ctl.valid && t_ctl.close)
        begin
            push       = 1'b1;
            push_ofs   = pend_v_reg ? pend_ofs_reg : '0;
            push_found = pend_v_reg;
            push_eos   = 1'b1;
        end
        else if (hit && t_ctl.flush)
        begin
            push     = pend_v_reg;
            push_ofs = pend_ofs_reg;
        end
        else if (hit)
        begin
            push = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_v_reg    <= 1'b0;
            first_reg     <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= push;
            if (t_ctl.valid && t_ctl.close)
            begin
                pend_v_reg <= 1'b0;
                first_reg  <= 1'b0;
            end
            else if (hit)
            begin
                first_reg <= 1'b1;
                if (t_ctl.flush)
                begin
                    pend_v_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && push)
        begin
            out_ofs_reg   <= push_ofs;
            out_found_reg <= push_found;
            out_eos_reg   <= push_eos;
        end
        if (adv && hit && t_ctl.flush)
        begin
            pend_ofs_reg <= ofs_ext[RES_W-1:0];
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.match_offset = out_ofs_reg;
    assign out_ch.found        = out_found_reg;
    assign out_ch.end_of_scan  = out_eos_reg;

`ifndef SYNTHESIS
    a_no_pend_on_plain: assert property (@(posedge clk) disable iff (!rst_n)
        (t_ctl.valid && !t_ctl.flush && !t_ctl.close) |-> !pend_v_reg)
        else $error("held result while a non-flush start reached the tail");

    a_close_gives_end: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && t_ctl.valid && t_ctl.close) |=> (out_valid_reg && out_eos_reg))
        else $error("end entry did not produce an end result");

    a_last_starts_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.last_byte) |=> (flush_reg && !in_ch.ready))
        else $error("last byte did not start the flush");

    a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_found_reg) |-> (out_eos_reg && out_ofs_reg == '0))
        else $error("bare result is not a clean end marker");
`endif

endmodule
